/* rtl/rts_pkg.sv */
// Shared types, codes and constants for the reaction time sequencer.
`timescale 1ns / 1ps
`default_nettype none

package rts_pkg;

    // Timestamp and duration widths
    localparam int TIME_BITS     = 32;
    localparam int DUR_BITS      = 31;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // LED timing in milliseconds
    localparam logic [TIME_BITS-1:0] SUCCESS_ON_MS     = 32'd125;
    localparam logic [TIME_BITS-1:0] SUCCESS_PERIOD_MS = 32'd250;
    localparam logic [TIME_BITS-1:0] SUCCESS_END_MS    = 32'd500;

    // Ready blink: lit while floor(e / 250) is even, i.e. e mod 500 < 250.
    // floor(e / 250) = floor((e >> 1) / 125), done as a multiply by an exact
    // reciprocal of 125 for 31-bit dividends.
    localparam logic [31:0] RECIP_125   = 32'd2199023256;
    localparam int          RECIP_SHIFT = 38;

    // Register reset values
    localparam logic [DUR_BITS-1:0] RESET_READY_MS    = 31'd2000;
    localparam logic [DUR_BITS-1:0] RESET_WAIT_MS     = 31'd3000;
    localparam logic [DUR_BITS-1:0] RESET_RESPONSE_MS = 31'd1000;
    localparam logic [DUR_BITS-1:0] RESET_HOLD_MS     = 31'd2000;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_READY    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAIT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESPONSE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD     = 3'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_AWAIT   = 3'd1,
        PH_READY   = 3'd2,
        PH_WAIT    = 3'd3,
        PH_CUE     = 3'd4,
        PH_SUCCESS = 3'd5,
        PH_FAILURE = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        OC_NONE      = 2'd0,
        OC_PREMATURE = 2'd1,
        OC_TIMEOUT   = 2'd2,
        OC_SUCCESS   = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        LED_OFF     = 3'd0,
        LED_READY   = 3'd1,
        LED_CUE     = 3'd2,
        LED_SUCCESS = 3'd3,
        LED_FAILURE = 3'd4
    } led_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] now;
        logic                 held;
        logic                 press_edge;
        logic                 release_edge;
    } item_t;

    typedef struct packed {
        logic                 status;
        logic [2:0]           phase;
        logic [1:0]           outcome;
        logic [2:0]           led_pattern;
        logic                 led_lit;
        logic                 cue_shown;
        logic [TIME_BITS-1:0] cue_stamp;
        logic                 cue_stamp_valid;
        logic [DUR_BITS-1:0]  reaction_ms;
        logic                 reaction_valid;
    } result_t;

    typedef struct packed {
        logic [DUR_BITS-1:0] ready_ms;
        logic [DUR_BITS-1:0] wait_ms;
        logic [DUR_BITS-1:0] response_limit_ms;
        logic [DUR_BITS-1:0] result_hold_ms;
    } cfg_regs_t;

    // Sequencer state as seen by the output stage
    typedef struct packed {
        logic                 valid;
        logic                 status;
        phase_t               phase;
        outcome_t             outcome;
        logic [TIME_BITS-1:0] elapsed;
        logic [TIME_BITS-1:0] cue_at;
        logic                 cue_rec;
        logic [DUR_BITS-1:0]  reaction;
        logic                 react_rec;
    } core_state_t;

endpackage

`default_nettype wire

/* rtl/rts_cfg.sv */
// Configuration register file for the four phase durations.
`timescale 1ns / 1ps
`default_nettype none

module rts_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [rts_pkg::CFG_IDX_BITS-1:0]  wr_index,
    input  wire logic [rts_pkg::CFG_DATA_BITS-1:0] wr_data,
    output      rts_pkg::cfg_regs_t                regs
);
    import rts_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    // Index decode; writes beyond the list are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_READY:    regs_next.ready_ms          = wr_data[DUR_BITS-1:0];
                CFG_WAIT:     regs_next.wait_ms           = wr_data[DUR_BITS-1:0];
                CFG_RESPONSE: regs_next.response_limit_ms = wr_data[DUR_BITS-1:0];
                CFG_HOLD:     regs_next.result_hold_ms    = wr_data[DUR_BITS-1:0];
                default:      regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ready_ms          <= RESET_READY_MS;
            regs_reg.wait_ms           <= RESET_WAIT_MS;
            regs_reg.response_limit_ms <= RESET_RESPONSE_MS;
            regs_reg.result_hold_ms    <= RESET_HOLD_MS;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

/* rtl/rts_core.sv */
// Phase sequencer: timestamp check, deadlines and round bookkeeping.
`timescale 1ns / 1ps
`default_nettype none

module rts_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            take,
    input  wire rts_pkg::item_t  item,
    input  wire rts_pkg::cfg_regs_t cfg,
    output      rts_pkg::core_state_t state
);
    import rts_pkg::*;

    phase_t               phase_reg,     phase_next;
    outcome_t             outcome_reg,   outcome_next;
    logic                 status_reg,    status_next;
    logic [TIME_BITS-1:0] entered_reg,   entered_next;
    logic [TIME_BITS-1:0] cue_at_reg,    cue_at_next;
    logic [TIME_BITS-1:0] last_reg,      last_next;
    logic [TIME_BITS-1:0] elapsed_reg,   elapsed_next;
    logic [DUR_BITS-1:0]  reaction_reg,  reaction_next;
    logic                 seen_reg,      seen_next;
    logic                 cue_rec_reg,   cue_rec_next;
    logic                 react_rec_reg, react_rec_next;
    logic                 valid_reg,     valid_next;

    logic [TIME_BITS-1:0] el;
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS-1:0] since_cue;
    logic                 ok;
    logic                 go;
    phase_t               go_phase;

    // Wrapping distances from the stored times
    assign el        = item.now - entered_reg;
    assign gap       = item.now - last_reg;
    assign since_cue = item.now - cue_at_reg;
    // A forward jump of half the range or more, or a backward step, shows as a set top bit
    assign ok        = !seen_reg || !gap[TIME_BITS-1];

    // Next state and bookkeeping
    always_comb
    begin
        phase_next     = phase_reg;
        outcome_next   = outcome_reg;
        status_next    = status_reg;
        entered_next   = entered_reg;
        cue_at_next    = cue_at_reg;
        last_next      = last_reg;
        elapsed_next   = elapsed_reg;
        reaction_next  = reaction_reg;
        seen_next      = seen_reg;
        cue_rec_next   = cue_rec_reg;
        react_rec_next = react_rec_reg;
        valid_next     = adv ? take : valid_reg;
        go             = 1'b0;
        go_phase       = phase_reg;

        if (take)
        begin
            if (!ok)
            begin
                status_next = 1'b1;
            end
            else
            begin
                status_next = 1'b0;
                last_next   = item.now;
                seen_next   = 1'b1;
                unique case (phase_reg)
                    PH_AWAIT:
                    begin
                        if (item.release_edge || !item.held)
                        begin
                            go       = 1'b1;
                            go_phase = PH_READY;
                        end
                    end
                    PH_READY:
                    begin
                        if (el >= {1'b0, cfg.ready_ms})
                        begin
                            go       = 1'b1;
                            go_phase = PH_WAIT;
                        end
                    end
                    PH_WAIT:
                    begin
                        if (item.press_edge)
                        begin
                            outcome_next = OC_PREMATURE;
                            go           = 1'b1;
                            go_phase     = PH_FAILURE;
                        end
                        else if (el >= {1'b0, cfg.wait_ms})
                        begin
                            cue_at_next  = item.now;
                            cue_rec_next = 1'b1;
                            go           = 1'b1;
                            go_phase     = PH_CUE;
                        end
                    end
                    PH_CUE:
                    begin
                        // timeout wins over a press in the same item
                        if (el >= {1'b0, cfg.response_limit_ms})
                        begin
                            outcome_next = OC_TIMEOUT;
                            go           = 1'b1;
                            go_phase     = PH_FAILURE;
                        end
                        else if (item.press_edge)
                        begin
                            outcome_next   = OC_SUCCESS;
                            reaction_next  = since_cue[DUR_BITS-1:0];
                            react_rec_next = 1'b1;
                            go             = 1'b1;
                            go_phase       = PH_SUCCESS;
                        end
                    end
                    PH_SUCCESS, PH_FAILURE:
                    begin
                        if (el >= {1'b0, cfg.result_hold_ms})
                        begin
                            go       = 1'b1;
                            go_phase = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        // idle: a press starts a new round
                        if (item.press_edge)
                        begin
                            outcome_next   = OC_NONE;
                            cue_rec_next   = 1'b0;
                            react_rec_next = 1'b0;
                            go             = 1'b1;
                            go_phase       = PH_AWAIT;
                        end
                    end
                endcase

                // Elapsed time in phase at the last accepted time
                if (go)
                begin
                    phase_next   = go_phase;
                    entered_next = item.now;
                    elapsed_next = {TIME_BITS{1'b0}};
                end
                else
                begin
                    elapsed_next = el;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            outcome_reg   <= OC_NONE;
            status_reg    <= 1'b0;
            entered_reg   <= {TIME_BITS{1'b0}};
            cue_at_reg    <= {TIME_BITS{1'b0}};
            last_reg      <= {TIME_BITS{1'b0}};
            elapsed_reg   <= {TIME_BITS{1'b0}};
            reaction_reg  <= {DUR_BITS{1'b0}};
            seen_reg      <= 1'b0;
            cue_rec_reg   <= 1'b0;
            react_rec_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            outcome_reg   <= outcome_next;
            status_reg    <= status_next;
            entered_reg   <= entered_next;
            cue_at_reg    <= cue_at_next;
            last_reg      <= last_next;
            elapsed_reg   <= elapsed_next;
            reaction_reg  <= reaction_next;
            seen_reg      <= seen_next;
            cue_rec_reg   <= cue_rec_next;
            react_rec_reg <= react_rec_next;
            valid_reg     <= valid_next;
        end
    end

    assign state.valid     = valid_reg;
    assign state.status    = status_reg;
    assign state.phase     = phase_reg;
    assign state.outcome   = outcome_reg;
    assign state.elapsed   = elapsed_reg;
    assign state.cue_at    = cue_at_reg;
    assign state.cue_rec   = cue_rec_reg;
    assign state.reaction  = reaction_reg;
    assign state.react_rec = react_rec_reg;

endmodule

`default_nettype wire

/* rtl/rts_led.sv */
// Output stage: LED pattern and level, result register.
`timescale 1ns / 1ps
`default_nettype none

module rts_led (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire rts_pkg::core_state_t state,
    output      logic                 result_valid,
    output      rts_pkg::result_t     result
);
    import rts_pkg::*;

    logic                          valid_reg;
    result_t                       result_reg;
    result_t                       result_next;
    logic [TIME_BITS+31-1:0]       prod;
    logic                          ready_lit;
    logic                          success_lit;
    led_t                          pattern;
    logic                          lit;

    // Ready blink from the parity of floor(elapsed / 250)
    assign prod      = {32'b0, state.elapsed[TIME_BITS-1:1]} * {{(TIME_BITS-1){1'b0}}, RECIP_125};
    assign ready_lit = !prod[RECIP_SHIFT];

    // Two success pulses of 125 ms, 250 ms apart
    assign success_lit = (state.elapsed < SUCCESS_ON_MS) ||
                         ((state.elapsed >= SUCCESS_PERIOD_MS) &&
                          (state.elapsed < SUCCESS_PERIOD_MS + SUCCESS_ON_MS) &&
                          (state.elapsed < SUCCESS_END_MS));

    // Pattern and level decode
    always_comb
    begin
        unique case (state.phase)
            PH_READY:
            begin
                pattern = LED_READY;
                lit     = ready_lit;
            end
            PH_CUE:
            begin
                pattern = LED_CUE;
                lit     = 1'b1;
            end
            PH_SUCCESS:
            begin
                pattern = LED_SUCCESS;
                lit     = success_lit;
            end
            PH_FAILURE:
            begin
                pattern = LED_FAILURE;
                lit     = 1'b1;
            end
            default:
            begin
                pattern = LED_OFF;
                lit     = 1'b0;
            end
        endcase
    end

    // Result assembly
    always_comb
    begin
        result_next.status          = state.status;
        result_next.phase           = state.phase;
        result_next.outcome         = state.outcome;
        result_next.led_pattern     = pattern;
        result_next.led_lit         = lit;
        result_next.cue_shown       = (state.phase == PH_CUE);
        result_next.cue_stamp       = state.cue_at;
        result_next.cue_stamp_valid = state.cue_rec;
        result_next.reaction_ms     = state.reaction;
        result_next.reaction_valid  = state.react_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= state.valid;
        end
    end

    // Payload holds while the result is stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* rtl/reaction_time_sequencer.sv */
// Top level of the reaction time sequencer.
//
//   channel  | direction | signals                                   | transfer when
//   item     | in        | item_valid, item_stall, item              | valid && !stall
//   result   | out       | result_valid, result_stall, result        | valid && !stall
//   cfg      | in        | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// One item per cycle while the result is not stalled; after its item transfers,
// each result is registered by the phase sequencer, then by the LED stage with its
// reciprocal multiply.
// Reset (async, active low) restores the register defaults and the idle phase.
// A stalled result holds both stages; item_stall follows result_stall then.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module reaction_time_sequencer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output      logic                              item_stall,
    input  wire rts_pkg::item_t                    item,
    output      logic                              result_valid,
    input  wire logic                              result_stall,
    output      rts_pkg::result_t                  result,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [rts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rts_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import rts_pkg::*;

    logic        adv;
    logic        take;
    cfg_regs_t   cfg;
    core_state_t state;

    // Pipeline moves whenever the result register is free or draining
    assign adv        = !result_valid || !result_stall;
    assign item_stall = !adv;
    assign take       = item_valid && adv;
    assign cfg_ready  = 1'b1;

    rts_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (cfg)
    );

    rts_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .take  (take),
        .item  (item),
        .cfg   (cfg),
        .state (state)
    );

    rts_led u_led (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .state        (state),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

/* rtl/rts_checker.sv */
// Port-level checks for the reaction time sequencer and their bind.
`timescale 1ns / 1ps
`default_nettype none

module rts_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    input  wire logic                              item_stall,
    input  wire logic                              result_valid,
    input  wire logic                              result_stall,
    input  wire rts_pkg::result_t                  result
);
    import rts_pkg::*;

    // A stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // Input backpressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item stalled without a stalled result");

    // A transferred item shows up as a valid result when the output does not stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n && item_valid && !item_stall, 2) &&
         $past(rst_n && !(result_valid && result_stall), 1)) |-> result_valid)
        else $error("result missing two cycles after item transfer");

    // A reaction time only exists after a cue in the same round
    a_reaction_after_cue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.reaction_valid |-> result.cue_stamp_valid)
        else $error("reaction recorded without a cue stamp");

endmodule

bind reaction_time_sequencer rts_checker u_rts_checker (.*);

`default_nettype wire

/* verif/tb_reaction_time_sequencer.sv */
// Self-checking testbench for the reaction time sequencer: directed rounds, random rounds.
`timescale 1ns / 1ps

module tb_reaction_time_sequencer;

    import rts_pkg::*;

    // LED timing and timestamp window
    localparam logic [31:0] READY_BLINK_MS = 32'd500;
    localparam logic [31:0] READY_LIT_MS   = 32'd250;
    localparam logic [31:0] WIN_BLINK_MS   = 32'd250;
    localparam logic [31:0] WIN_LIT_MS     = 32'd125;
    localparam logic [31:0] WIN_PULSE_END  = 32'd500;
    localparam logic [31:0] HALF_RANGE     = 32'h7fff_ffff;
    localparam logic [31:0] JUMP_TOO_FAR   = 32'h8000_0000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    reaction_time_sequencer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow of the sequencer: registers and round state
    cfg_regs_t timing = '{RESET_READY_MS, RESET_WAIT_MS, RESET_RESPONSE_MS, RESET_HOLD_MS};
    phase_t cur_phase = PH_IDLE;
    outcome_t cur_outcome = OC_NONE;
    logic jump_flag = 1'b0;
    logic [31:0] entered_ms = '0;
    logic [31:0] cue_ms = '0;
    logic [31:0] last_ms = '0;
    logic [30:0] react_ms = '0;
    logic have_time = 1'b0;
    logic cue_valid = 1'b0;
    logic react_valid = 1'b0;

    item_t feed_q[$];
    result_t expected_status[$];
    int items_queued = 0;
    int items_taken = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    bit item_moved = 1'b0;
    bit steady_mode = 1'b0;

    // Stimulus time base and button level
    logic [31:0] stim_ms = 32'hffff_f000;
    bit btn_down = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void move_to(phase_t next, logic [31:0] stamp);
        cur_phase = next;
        entered_ms = stamp;
    endfunction

    // Advance the shadow by one item and return the status it reports
    function automatic result_t predict_status(item_t it);
        logic [31:0] span;
        logic [31:0] elapsed;
        logic [31:0] gap;
        result_t r;
        gap = it.now - last_ms;
        if (have_time && it.now != last_ms && gap > HALF_RANGE)
        begin
            jump_flag = 1'b1;
        end
        else
        begin
            jump_flag = 1'b0;
            last_ms = it.now;
            have_time = 1'b1;
            span = it.now - entered_ms;
            case (cur_phase)
                PH_AWAIT:
                begin
                    if (it.release_edge || !it.held)
                        move_to(PH_READY, it.now);
                end
                PH_READY:
                begin
                    if (span >= {1'b0, timing.ready_ms})
                        move_to(PH_WAIT, it.now);
                end
                PH_WAIT:
                begin
                    if (it.press_edge)
                    begin
                        cur_outcome = OC_PREMATURE;
                        move_to(PH_FAILURE, it.now);
                    end
                    else if (span >= {1'b0, timing.wait_ms})
                    begin
                        cue_ms = it.now;
                        cue_valid = 1'b1;
                        move_to(PH_CUE, it.now);
                    end
                end
                PH_CUE:
                begin
                    // timeout takes precedence over a press in the same item
                    if (span >= {1'b0, timing.response_limit_ms})
                    begin
                        cur_outcome = OC_TIMEOUT;
                        move_to(PH_FAILURE, it.now);
                    end
                    else if (it.press_edge)
                    begin
                        cur_outcome = OC_SUCCESS;
                        gap = it.now - cue_ms;
                        react_ms = gap[30:0];
                        react_valid = 1'b1;
                        move_to(PH_SUCCESS, it.now);
                    end
                end
                PH_SUCCESS, PH_FAILURE:
                begin
                    if (span >= {1'b0, timing.result_hold_ms})
                        move_to(PH_IDLE, it.now);
                end
                default:
                begin
                    // new round: flags cleared, stamps kept
                    if (it.press_edge)
                    begin
                        cur_outcome = OC_NONE;
                        cue_valid = 1'b0;
                        react_valid = 1'b0;
                        move_to(PH_AWAIT, it.now);
                    end
                end
            endcase
        end

        elapsed = last_ms - entered_ms;
        r = '0;
        r.status = jump_flag;
        r.phase = cur_phase;
        r.outcome = cur_outcome;
        case (cur_phase)
            PH_READY:
            begin
                r.led_pattern = LED_READY;
                r.led_lit = (elapsed % READY_BLINK_MS) < READY_LIT_MS;
            end
            PH_CUE:
            begin
                r.led_pattern = LED_CUE;
                r.led_lit = 1'b1;
            end
            PH_SUCCESS:
            begin
                r.led_pattern = LED_SUCCESS;
                r.led_lit = elapsed < WIN_PULSE_END && (elapsed % WIN_BLINK_MS) < WIN_LIT_MS;
            end
            PH_FAILURE:
            begin
                r.led_pattern = LED_FAILURE;
                r.led_lit = 1'b1;
            end
            default:
            begin
                r.led_pattern = LED_OFF;
                r.led_lit = 1'b0;
            end
        endcase
        r.cue_shown = cur_phase == PH_CUE;
        r.cue_stamp = cue_ms;
        r.cue_stamp_valid = cue_valid;
        r.reaction_ms = react_ms;
        r.reaction_valid = react_valid;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected %h, got %h", what, want, got);
        end
    endtask

    task automatic compare_status(input result_t got);
        result_t want;
        if (expected_status.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("result with no pending expectation: %h", got);
        end
        else
        begin
            want = expected_status.pop_front();
            check_field("status", 32'(got.status), 32'(want.status));
            check_field("phase", 32'(got.phase), 32'(want.phase));
            check_field("outcome", 32'(got.outcome), 32'(want.outcome));
            check_field("led_pattern", 32'(got.led_pattern), 32'(want.led_pattern));
            check_field("led_lit", 32'(got.led_lit), 32'(want.led_lit));
            check_field("cue_shown", 32'(got.cue_shown), 32'(want.cue_shown));
            check_field("cue_stamp", got.cue_stamp, want.cue_stamp);
            check_field("cue_stamp_valid", 32'(got.cue_stamp_valid),
                        32'(want.cue_stamp_valid));
            check_field("reaction_ms", 32'(got.reaction_ms), 32'(want.reaction_ms));
            check_field("reaction_valid", 32'(got.reaction_valid),
                        32'(want.reaction_valid));
        end
    endtask

    // Item driver and result stall, updated on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_moved)
        begin
            if (feed_q.size() != 0 && (steady_mode || $urandom_range(99) >= 31))
            begin
                item_valid <= 1'b1;
                item <= feed_q.pop_front();
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        result_stall <= !steady_mode && ($urandom_range(99) < 31);
    end

    // Monitor: predict on each item transfer, check each result transfer, watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_moved = 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            item_moved = item_valid && !item_stall;
            if (item_moved)
            begin
                expected_status.push_back(predict_status(item));
                items_taken++;
            end
            if (result_valid && !result_stall)
                compare_status(result);
            if (item_moved || (result_valid && !result_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_item(input logic [31:0] stamp, input bit held, input bit press,
                              input bit rel);
        item_t it;
        it.now = stamp;
        it.held = held;
        it.press_edge = press;
        it.release_edge = rel;
        feed_q.push_back(it);
        items_queued++;
    endtask

    task automatic step_item(input logic [31:0] delta, input bit held, input bit press,
                             input bit rel);
        stim_ms += delta;
        queue_item(stim_ms, held, press, rel);
    endtask

    // Waits for every result, then lets the pipeline settle
    task automatic wait_drained();
        @(negedge clk);
        while (items_taken != items_queued || expected_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_READY:    timing.ready_ms = value[30:0];
            CFG_WAIT:     timing.wait_ms = value[30:0];
            CFG_RESPONSE: timing.response_limit_ms = value[30:0];
            CFG_HOLD:     timing.result_hold_ms = value[30:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [31:0] ready, input logic [31:0] waiting,
                              input logic [31:0] response, input logic [31:0] hold);
        write_reg(CFG_READY, ready);
        write_reg(CFG_WAIT, waiting);
        write_reg(CFG_RESPONSE, response);
        write_reg(CFG_HOLD, hold);
    endtask

    // Mostly coherent button activity with small time steps; some glitches and bad jumps
    task automatic random_items(input int count, input int max_step);
        int pick;
        logic [31:0] stamp;
        bit h;
        bit p;
        bit r;
        repeat (count)
        begin
            pick = $urandom_range(99);
            p = 1'b0;
            r = 1'b0;
            if (!btn_down && $urandom_range(99) < 30)
            begin
                p = 1'b1;
                btn_down = 1'b1;
            end
            else if (btn_down && $urandom_range(99) < 50)
            begin
                r = 1'b1;
                btn_down = 1'b0;
            end
            h = btn_down;
            if (pick < 4)
                {h, p, r} = 3'($urandom_range(7));

            if (pick >= 4 && pick < 7)
            begin
                // forward jump past the window: rejected
                stamp = stim_ms + JUMP_TOO_FAR + $urandom_range(0, HALF_RANGE);
            end
            else if (pick >= 7 && pick < 9)
            begin
                // backward step: rejected
                stamp = stim_ms - $urandom_range(1, JUMP_TOO_FAR);
            end
            else
            begin
                if (pick < 11)
                    stim_ms += $urandom_range(0, HALF_RANGE);
                else if (pick >= 14)
                    stim_ms += $urandom_range(0, max_step);
                stamp = stim_ms;
            end
            queue_item(stamp, h, p, r);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed round on reset timing, starting just below the wrap point
        step_item(0, 0, 0, 0);
        step_item(0, 1, 1, 0);
        step_item(10, 1, 0, 0);
        queue_item(stim_ms + JUMP_TOO_FAR, 1, 0, 0);
        step_item(10, 0, 0, 1);
        step_item(1999, 0, 0, 0);
        step_item(1, 0, 0, 0);
        step_item(2999, 0, 0, 0);
        step_item(1, 0, 0, 0);
        step_item(1000, 1, 1, 0);
        step_item(1999, 0, 0, 1);
        step_item(1, 0, 0, 0);
        step_item(0, 1, 1, 0);
        step_item(5, 1, 0, 1);
        step_item(2000, 1, 0, 0);
        step_item(100, 1, 1, 0);
        step_item(2000, 0, 0, 1);
        step_item(3, 1, 1, 0);
        step_item(4, 0, 0, 0);
        step_item(2000, 0, 0, 0);
        step_item(3000, 0, 0, 0);
        step_item(123, 1, 1, 0);
        step_item(130, 1, 0, 0);
        step_item(120, 0, 0, 1);
        step_item(HALF_RANGE, 0, 0, 0);
        queue_item(stim_ms + JUMP_TOO_FAR, 0, 0, 0);
        wait_drained();

        // Extreme timing: widest durations, a masked zero wait, unused index
        set_timing(HALF_RANGE, JUMP_TOO_FAR, HALF_RANGE, 32'd1);
        write_reg(CFG_UNUSED, 32'hffff_ffff);
        step_item(1, 1, 1, 0);
        step_item(1, 0, 0, 1);
        step_item(HALF_RANGE - 1, 0, 0, 0);
        step_item(1, 0, 0, 0);
        step_item(0, 0, 0, 0);
        step_item(5, 1, 1, 0);
        step_item(1, 0, 0, 1);
        wait_drained();

        // Short timing, no idling on either side
        btn_down = 1'b0;
        steady_mode = 1'b1;
        set_timing($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(1, 8));
        random_items(260, 6);
        wait_drained();
        steady_mode = 1'b0;

        // Medium timing long enough to see both LED blink patterns
        set_timing(32'd600, 32'd400, 32'd700, 32'd900);
        random_items(240, 150);
        wait_drained();

        set_timing($urandom_range(1, 60), $urandom_range(1, 60), $urandom_range(1, 60),
                   $urandom_range(1, 60));
        random_items(220, 30);
        wait_drained();

        set_timing(32'd2000, 32'd3000, 32'd1000, 32'd2000);
        random_items(230, 700);
        wait_drained();

        if (mismatches == 0 && expected_status.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
